// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker in fpsc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("%m: property failed");

`endif

// File: hw/rtl/fpsc_pkg.sv
package fpsc_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int ANGLE_W       = 24;
   localparam int VALUE_W       = 32;

   // Pipeline depth of each part, and the number of series terms
   localparam int FRONT_STAGES = 6;
   localparam int STEP_STAGES  = 2;
   localparam int BLEND_STAGES = 2;
   localparam int TERM_COUNT   = 9;

   // Reciprocal constants for division by 360 and by 20
   localparam int          RECIP_SHIFT = 28;
   localparam logic [23:0] RECIP_360   = 24'((1 << RECIP_SHIFT) / 360);
   localparam logic [23:0] RECIP_20    = 24'((1 << RECIP_SHIFT) / 20);
   localparam int          DEG_360     = 360;
   localparam int          DEG_20      = 20;

   // One item as it flows through the series pipeline
   typedef struct packed {
      logic        op;
      logic        blend;
      logic [31:0] x;
      logic [31:0] ratio;
      logic [31:0] v;
      logic [31:0] acc;
   } sc_item_type;

   // Degree to radian factor, truncated to frac_bits fraction bits
   function automatic logic [31:0] deg2rad_fx(int frac_bits);
      longint unsigned n;
      n = 64'd174532925199 << frac_bits;
      return 32'(n / 64'd10000000000000);
   endfunction

   // Multiplier for exact truncating division of a magnitude up to 2^31
   function automatic logic [31:0] div_magic(int idx);
      logic [31:0] m;
      case (idx)
         3:       m = 32'hAAAA_AAAB;
         5:       m = 32'hCCCC_CCCD;
         6:       m = 32'hAAAA_AAAB;
         7:       m = 32'h9249_2493;
         9:       m = 32'hE38E_38E4;
         default: m = 32'h8000_0000;
      endcase
      return m;
   endfunction

   function automatic int div_shift(int idx);
      int s;
      case (idx)
         1:       s = 31;
         2:       s = 32;
         3, 4:    s = 33;
         9:       s = 35;
         default: s = 34;
      endcase
      return s;
   endfunction

endpackage

// File: hw/rtl/fixed_point_sine_cosine.sv
// Fixed-point sine and cosine of an angle in degrees.
// Input channel req_*: req_op selects sine (0) or cosine (1), req_angle is
// a signed angle with FRAC_BITS fraction bits. A transfer happens when
// req_valid and req_ready are both high at a rising clock edge.
// Result channel rsp_*: rsp_value carries the result in the same format,
// transferred when rsp_valid and rsp_ready are both high.
// Throughput: one item per clock while the receiver is ready. The pipeline
// from input transfer to rsp_valid has 6 stages of range reduction and blend
// ratio, 2 stages for each of the 9 series terms (multiply, then divide by
// the term index), and 2 stages for the final blend.
// Each stage carries its own valid bit. When the receiver stalls, results
// hold in place and empty stages keep filling, so req_ready drops only once
// every stage holds an item.
// Reset (synchronous, active high) empties the pipeline; items in flight
// are dropped and rsp_valid goes low on the next edge.
module fixed_point_sine_cosine #(
   parameter int FRAC_BITS = fpsc_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic signed [fpsc_pkg::ANGLE_W-1:0]  req_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [fpsc_pkg::VALUE_W-1:0]  rsp_value
);
   import fpsc_pkg::*;

   localparam int NS = FRONT_STAGES + TERM_COUNT * STEP_STAGES + BLEND_STAGES;

   logic [NS-1:0] valid_ff, valid_in, en;

   // Stage advances when it is empty or its successor advances
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   // Move valid bits along with the data
   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NS-1];

   sc_item_type chain [0:TERM_COUNT];

   fpsc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .stage_en  (en[FRONT_STAGES-1:0]),
      .req_op    (req_op),
      .req_angle (req_angle),
      .item_out  (chain[0])
   );

   for (genvar j = 0; j < TERM_COUNT; j++) begin : g_term
      fpsc_step #(.FRAC_BITS(FRAC_BITS), .TERM_IDX(j + 1)) u_step (
         .clock    (clock),
         .stage_en (en[FRONT_STAGES + j * STEP_STAGES +: STEP_STAGES]),
         .item_in  (chain[j]),
         .item_out (chain[j+1])
      );
   end

   fpsc_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock    (clock),
      .stage_en (en[NS-1 -: BLEND_STAGES]),
      .item_in  (chain[TERM_COUNT]),
      .value    (rsp_value)
   );

endmodule

// File: hw/rtl/fpsc_front.sv
module fpsc_front #(
   parameter int FRAC_BITS = fpsc_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic [fpsc_pkg::FRONT_STAGES-1:0]       stage_en,
   input  logic                                    req_op,
   input  logic signed [fpsc_pkg::ANGLE_W-1:0]     req_angle,
   output fpsc_pkg::sc_item_type                   item_out
);
   import fpsc_pkg::*;

   localparam int MW = ANGLE_W - FRAC_BITS;
   localparam int RW = FRAC_BITS + 5;
   localparam int PW = MW + 24;
   localparam int QW = RW + 24;
   localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;
   localparam logic [31:0] D180   = 32'(180) << FRAC_BITS;
   localparam logic [31:0] D160   = 32'(160) << FRAC_BITS;
   localparam logic [31:0] D360   = 32'(360) << FRAC_BITS;
   localparam logic [31:0] NEG160 = 32'(0) - D160;
   localparam logic [31:0] D2R    = deg2rad_fx(FRAC_BITS);

   // Stage 1: offset the angle and estimate the turn count
   logic          s1_op_ff, s1_wrap_ff;
   logic [31:0]   s1_aoff_ff, aoff;
   logic [MW-1:0] s1_q_ff, q1;
   logic [PW-1:0] p1;

   always_comb begin
      aoff = {{(32 - ANGLE_W){req_angle[ANGLE_W-1]}}, req_angle} + D180;
      p1   = PW'(aoff[ANGLE_W-1:FRAC_BITS]) * PW'(RECIP_360);
      q1   = MW'(p1 >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_op_ff   <= req_op;
         s1_aoff_ff <= aoff;
         s1_wrap_ff <= $signed(aoff) > $signed(D360);
         s1_q_ff    <= q1;
      end
   end

   // Stage 2: finish the modulo and remove the offset
   logic          s2_op_ff;
   logic [31:0]   s2_a_ff, a2, ared;
   logic [MW-1:0] r2, r2c;

   always_comb begin
      r2   = s1_aoff_ff[ANGLE_W-1:FRAC_BITS] - MW'(s1_q_ff * MW'(DEG_360));
      r2c  = (r2 >= MW'(DEG_360)) ? r2 - MW'(DEG_360) : r2;
      ared = s1_wrap_ff ? ((32'(r2c) << FRAC_BITS) | 32'(s1_aoff_ff[FRAC_BITS-1:0]))
                        : s1_aoff_ff;
      a2   = ared - D180;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_op_ff <= s1_op_ff;
         s2_a_ff  <= a2;
      end
   end

   // Stage 3: blend region, radians, and estimate of the span quotient
   logic             s3_op_ff, s3_blend_ff, hi3, lo3;
   logic [31:0]      s3_x_ff, mag3, d3, xp3;
   logic [ANGLE_W-1:0] s3_d_ff;
   logic [MW-1:0]    s3_q_ff, q3;
   logic [PW-1:0]    p3;

   always_comb begin
      hi3  = $signed(s2_a_ff) > $signed(D160);
      lo3  = $signed(s2_a_ff) < $signed(NEG160);
      mag3 = lo3 ? 32'(0) - s2_a_ff : s2_a_ff;
      d3   = mag3 - D160;
      p3   = PW'(d3[ANGLE_W-1:FRAC_BITS]) * PW'(RECIP_20);
      q3   = MW'(p3 >> RECIP_SHIFT);
      xp3  = s2_a_ff * D2R;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_op_ff    <= s2_op_ff;
         s3_blend_ff <= hi3 | lo3;
         s3_x_ff     <= 32'($signed(xp3) >>> FRAC_BITS);
         s3_d_ff     <= d3[ANGLE_W-1:0];
         s3_q_ff     <= q3;
      end
   end

   // Stage 4: correct the span quotient, form the remainder
   logic          s4_op_ff, s4_blend_ff, ge4;
   logic [31:0]   s4_x_ff;
   logic [MW-1:0] s4_q_ff, r4, r4c;
   logic [RW-1:0] s4_rem_ff, rem4;

   always_comb begin
      r4   = s3_d_ff[ANGLE_W-1:FRAC_BITS] - MW'(s3_q_ff * MW'(DEG_20));
      ge4  = r4 >= MW'(DEG_20);
      r4c  = ge4 ? r4 - MW'(DEG_20) : r4;
      rem4 = (RW'(r4c) << FRAC_BITS) | RW'(s3_d_ff[FRAC_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_op_ff    <= s3_op_ff;
         s4_blend_ff <= s3_blend_ff;
         s4_x_ff     <= s3_x_ff;
         s4_q_ff     <= ge4 ? s3_q_ff + MW'(1) : s3_q_ff;
         s4_rem_ff   <= rem4;
      end
   end

   // Stage 5: estimate the fraction of the span
   logic          s5_op_ff, s5_blend_ff;
   logic [31:0]   s5_x_ff;
   logic [MW-1:0] s5_q_ff;
   logic [RW-1:0] s5_rem_ff, s5_e_ff;
   logic [QW-1:0] p5;

   assign p5 = QW'(s4_rem_ff) * QW'(RECIP_20);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_op_ff    <= s4_op_ff;
         s5_blend_ff <= s4_blend_ff;
         s5_x_ff     <= s4_x_ff;
         s5_q_ff     <= s4_q_ff;
         s5_rem_ff   <= s4_rem_ff;
         s5_e_ff     <= RW'(p5 >> RECIP_SHIFT);
      end
   end

   // Stage 6: correct the fraction and assemble the series item
   sc_item_type   item_ff, item_in;
   logic [RW-1:0] t6, rq6;

   always_comb begin
      t6            = s5_rem_ff - RW'(s5_e_ff * RW'(DEG_20));
      rq6           = (t6 >= RW'(DEG_20)) ? s5_e_ff + RW'(1) : s5_e_ff;
      item_in.op    = s5_op_ff;
      item_in.blend = s5_blend_ff;
      item_in.x     = s5_x_ff;
      item_in.ratio = (32'(s5_q_ff) << FRAC_BITS) + 32'(rq6);
      item_in.v     = ONE_FX;
      item_in.acc   = s5_op_ff ? ONE_FX : s5_x_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

// File: hw/rtl/fpsc_step.sv
module fpsc_step #(
   parameter int FRAC_BITS = fpsc_pkg::FRAC_BITS_DEF,
   parameter int TERM_IDX  = 1
) (
   input  logic                               clock,
   input  logic [fpsc_pkg::STEP_STAGES-1:0]   stage_en,
   input  fpsc_pkg::sc_item_type              item_in,
   output fpsc_pkg::sc_item_type              item_out
);
   import fpsc_pkg::*;

   localparam logic [31:0] MAGIC    = div_magic(TERM_IDX);
   localparam int          SHIFT    = div_shift(TERM_IDX);
   localparam bit          EVEN     = (TERM_IDX % 2) == 0;
   localparam bit          ODD3     = ((TERM_IDX % 2) == 1) && (TERM_IDX >= 3);
   localparam bit          POSITIVE = ((TERM_IDX % 4) == 0) || ((TERM_IDX % 4) == 1);

   // Stage A: multiply the running power by x
   sc_item_type a_ff, a_in;
   logic [31:0] prod;

   always_comb begin
      prod   = item_in.v * item_in.x;
      a_in   = item_in;
      a_in.v = 32'($signed(prod) >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_ff <= a_in;
      end
   end

   // Stage B: truncating divide by the term index, then accumulate the selected terms
   sc_item_type b_ff, b_in;
   logic        neg, use_term;
   logic [31:0] mag, q, vq;
   logic [63:0] mp;

   always_comb begin
      neg      = a_ff.v[31];
      mag      = neg ? 32'(0) - a_ff.v : a_ff.v;
      mp       = 64'(mag) * 64'(MAGIC);
      q        = 32'(mp >> SHIFT);
      vq       = neg ? 32'(0) - q : q;
      use_term = a_ff.op ? EVEN : ODD3;
      b_in     = a_ff;
      b_in.v   = vq;
      if (use_term) begin
         b_in.acc = POSITIVE ? a_ff.acc + vq : a_ff.acc - vq;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         b_ff <= b_in;
      end
   end

   assign item_out = b_ff;

endmodule

// File: hw/rtl/fpsc_blend.sv
module fpsc_blend #(
   parameter int FRAC_BITS = fpsc_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic [fpsc_pkg::BLEND_STAGES-1:0]    stage_en,
   input  fpsc_pkg::sc_item_type                item_in,
   output logic signed [fpsc_pkg::VALUE_W-1:0]  value
);
   import fpsc_pkg::*;

   localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

   // Stage A: scale the series sum by one minus the ratio
   sc_item_type a_ff, a_in;

   always_comb begin
      a_in   = item_in;
      a_in.v = item_in.acc * (ONE_FX - item_in.ratio);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_ff <= a_in;
      end
   end

   // Stage B: finish the blend toward zero or minus one, or pass the series sum unblended
   logic [31:0] value_ff, value_in, m;

   always_comb begin
      m = 32'($signed(a_ff.v) >>> FRAC_BITS);
      if (a_ff.blend) begin
         value_in = a_ff.op ? m - a_ff.ratio : m;
      end else begin
         value_in = a_ff.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         value_ff <= value_in;
      end
   end

   assign value = $signed(value_ff);

endmodule

// File: hw/rtl/fpsc_checker.sv
`include "assert_macros.svh"

module fpsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value
);

   // Pipeline is empty right after reset
   `ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid)

   // An empty output stage never blocks the input
   `ASSERT_CLK(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // A ready receiver lets every stage advance
   `ASSERT_CLK(a_ready_follows, clock, reset, rsp_ready |-> req_ready)

   // A stalled result holds
   `ASSERT_CLK(a_result_holds, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))

endmodule

bind fixed_point_sine_cosine fpsc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_value (rsp_value)
);

// File: tb/sv/fixed_point_sine_cosine_checker.sv
module fixed_point_sine_cosine_checker #(
   parameter int FRAC_BITS = fpsc_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [fpsc_pkg::ANGLE_W-1:0] req_angle,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [fpsc_pkg::VALUE_W-1:0] rsp_value,
   output int                                  pending_count,
   output int                                  error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] ONE_FX  = 32'd1 << FRAC_BITS;
   localparam logic [31:0] DEG_180 = 32'd180 << FRAC_BITS;
   localparam logic [31:0] DEG_160 = 32'd160 << FRAC_BITS;
   localparam logic [31:0] DEG_360 = 32'd360 << FRAC_BITS;
   localparam logic [31:0] SPAN    = DEG_180 - DEG_160;
   localparam logic [31:0] RAD_PER_DEG =
      32'((64'd174532925199 << FRAC_BITS) / 64'd10000000000000);

   logic [31:0] expected_values[$];

   function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
      logic [31:0] p;
      p = a * b;
      return $signed(p) >>> FRAC_BITS;
   endfunction

   // Truncate toward zero for a positive divisor
   function automatic logic [31:0] trunc_div(logic [31:0] x, logic [31:0] d);
      if (x[31]) return 32'd0 - ((32'd0 - x) / d);
      return x / d;
   endfunction

   function automatic logic [31:0] trunc_rem(logic [31:0] x, logic [31:0] d);
      if (x[31]) return 32'd0 - ((32'd0 - x) % d);
      return x % d;
   endfunction

   function automatic logic [31:0] span_ratio(logic [31:0] a);
      logic [31:0] q;
      logic [31:0] r;
      q = trunc_div(a, SPAN) << FRAC_BITS;
      r = trunc_div(trunc_rem(a, SPAN) << FRAC_BITS, SPAN);
      return q + r;
   endfunction

   function automatic logic [31:0] series_term(logic [31:0] x, int n);
      logic [31:0] v;
      v = ONE_FX;
      for (int i = 1; i <= n; i++) begin
         v = fx_mul(v, x);
         v = trunc_div(v, 32'(i));
      end
      return v;
   endfunction

   function automatic logic [31:0] predict_trig(logic is_cos, logic [23:0] angle);
      logic [31:0] a;
      logic [31:0] x;
      logic [31:0] val;
      logic [31:0] ratio;
      logic        high;
      logic        low;
      a = {{8{angle[23]}}, angle} + DEG_180;
      if ($signed(a) > $signed(DEG_360)) a = a % DEG_360;
      a = a - DEG_180;
      high  = $signed(a) > $signed(DEG_160);
      low   = $signed(a) < -$signed(DEG_160);
      ratio = span_ratio((low ? (32'd0 - a) : a) - DEG_160);
      x = fx_mul(a, RAD_PER_DEG);
      if (is_cos) begin
         val = ONE_FX - series_term(x, 2) + series_term(x, 4)
               - series_term(x, 6) + series_term(x, 8);
         if (high || low) val = fx_mul(val, ONE_FX - ratio) - ratio;
      end else begin
         val = x - series_term(x, 3) + series_term(x, 5)
               - series_term(x, 7) + series_term(x, 9);
         if (high || low) val = fx_mul(val, ONE_FX - ratio);
      end
      return val;
   endfunction

   assign pending_count = expected_values.size();

   // Predict on each input transfer, compare on each result transfer
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_values.push_back(predict_trig(req_op, req_angle));
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("unexpected result transfer: value %h", rsp_value);
            end else begin
               want = expected_values.pop_front();
               if (want !== rsp_value) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("value mismatch: expected %h actual %h", want, rsp_value);
               end
            end
         end
      end
   end
endmodule

// File: tb/sv/tb_fixed_point_sine_cosine.sv
module tb_fixed_point_sine_cosine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_COUNT = 1350;
   localparam int FB = fpsc_pkg::FRAC_BITS_DEF;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_op;
   logic signed [fpsc_pkg::ANGLE_W-1:0] req_angle;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [fpsc_pkg::VALUE_W-1:0] rsp_value;
   int                                  pending_count;
   int                                  error_count;
   int                                  sent;
   int                                  phase;

   fixed_point_sine_cosine uut (.*);

   fixed_point_sine_cosine_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Directed angles in whole degrees, then raw extremes, other fixed angles and random values
   int directed_deg[11] = '{0, 90, -90, 160, -160, 161, -161, 180, -180, 181, -181};

   function automatic logic [23:0] pick_angle(int n);
      int r;
      if (n < 22) begin
         if (n < 11) return 24'(directed_deg[n] * (1 << FB));
         case (n)
            11: return 24'h7FFFFF;
            12: return 24'h800000;
            13: return 24'(359 * (1 << FB) + 255);
            14: return 24'(-170 * (1 << FB) + 3);
            15: return 24'(541 * (1 << FB));
            default: return 24'($urandom);
         endcase
      end
      r = $urandom_range(99);
      if (r < 65) return 24'(int'($urandom_range(92160)) - 46080);
      if (r < 80) return 24'(int'($urandom_range(4096)) - 2048 +
                             ($urandom_range(1) ? 46080 : -46080));
      return 24'($urandom);
   endfunction

   // Receiver readiness per idling phase
   always @(posedge clock) begin
      case (phase)
         0: rsp_ready <= ($urandom_range(99) >= 65);
         1: rsp_ready <= ($urandom_range(99) >= 28);
         default: rsp_ready <= 1'b1;
      endcase
   end

   initial begin
      int idle_pct;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_op    = 1'b0;
      req_angle = '0;
      sent      = 0;
      phase     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Hold payload until transfer, then offer the next item or idle
      while (sent < ITEM_COUNT) begin
         @(posedge clock);
         if (req_valid && req_ready) sent = sent + 1;
         phase = sent * 3 / ITEM_COUNT;
         idle_pct = (phase == 0) ? 28 : (phase == 1) ? 65 : 0;
         if (!req_valid || req_ready) begin
            if (sent < ITEM_COUNT && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_op    <= (sent < 22) ? sent[0] ^ (sent >= 11) : 1'($urandom);
               req_angle <= pick_angle(sent);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
      req_valid <= 1'b0;
      phase = 2;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("fixed_point_sine_cosine regression: pass");
      else
         $display("fixed_point_sine_cosine regression: fail");
      $finish;
   end

   initial begin
      #2ms;
      $display("fixed_point_sine_cosine regression: fail");
      $finish;
   end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/fpsc_pkg.sv
hw/rtl/fpsc_front.sv
hw/rtl/fpsc_step.sv
hw/rtl/fpsc_blend.sv
hw/rtl/fixed_point_sine_cosine.sv
hw/rtl/fpsc_checker.sv
tb/sv/fixed_point_sine_cosine_checker.sv
tb/sv/tb_fixed_point_sine_cosine.sv
